// File: rtl/sha384_hash_engine_assert.svh
`ifndef SHA384_HASH_ENGINE_ASSERT_SVH
`define SHA384_HASH_ENGINE_ASSERT_SVH
// assertion helpers
`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SHA_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// File: rtl/sha384_pkg.sv
package sha384_pkg;

  localparam int unsigned QDepth = 4;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_ZERO,
    OP_LEN
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] word;
    logic        last;
  } cmd_t;

  localparam logic [63:0] INIT_H [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// File: rtl/sha384_front.sv
module sha384_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [63:0]         s_word_i,
  input  logic [3:0]          s_nbytes_i,
  input  logic                s_last_i,
  output logic                c_valid_o,
  input  logic                c_ready_i,
  output sha384_pkg::cmd_t    c_cmd_o
);
  import sha384_pkg::*;

  // padding sequencer: turns message words into block commands
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN
  } state_e;

  state_e      state_q;
  logic [3:0]  fill_q;
  logic [63:0] count_q;
  logic [63:0] count_inc;
  logic [3:0]  nb;
  logic [63:0] keep;
  logic [63:0] merged;

  assign nb = (s_nbytes_i > 4'd8) ? 4'd8 : s_nbytes_i;
  assign keep = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nb, 3'b000});
  assign merged = (s_word_i & keep) | (64'h8000000000000000 >> {nb, 3'b000});
  assign count_inc = s_last_i ? 64'({nb, 3'b000}) : 64'd64;

  assign s_tready_o = (state_q == ST_IDLE) && c_ready_i;

  always_comb begin
    c_valid_o = 1'b0;
    c_cmd_o = '{op: OP_DATA, word: s_word_i, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        c_valid_o = s_tvalid_i;
        if (s_last_i && nb != 4'd8) c_cmd_o.word = merged;
      end
      ST_PAD: begin
        c_valid_o = 1'b1;
        c_cmd_o.word = 64'h8000000000000000;
      end
      ST_ZERO: begin
        c_valid_o = 1'b1;
        c_cmd_o.op = OP_ZERO;
        c_cmd_o.word = '0;
      end
      ST_LEN: begin
        c_valid_o = 1'b1;
        c_cmd_o.op = OP_LEN;
        c_cmd_o.word = count_q;
        c_cmd_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      count_q <= '0;
    end else if (c_valid_o && c_ready_i) begin
      fill_q <= fill_q + 4'd1;
      unique case (state_q)
        ST_IDLE: begin
          count_q <= count_q + count_inc;
          if (s_last_i) begin
            if (nb == 4'd8) state_q <= ST_PAD;
            else state_q <= ST_ZERO;
          end
        end
        ST_PAD: state_q <= ST_ZERO;
        ST_ZERO: if (fill_q == 4'd14) state_q <= ST_LEN;
        ST_LEN: begin
          state_q <= ST_IDLE;
          count_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/sha384_queue.sv
module sha384_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sha384_pkg::cmd_t in_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sha384_pkg::cmd_t out_cmd_o
);
  import sha384_pkg::*;

  localparam int unsigned AW = $clog2(QDepth);

  cmd_t        mem_q [QDepth];
  logic [AW:0] wr_q, rd_q;

  assign in_ready_o = (wr_q - rd_q) != (AW+1)'(QDepth);
  assign out_valid_o = wr_q != rd_q;
  assign out_cmd_o = mem_q[rd_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wr_q[AW-1:0]] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (in_valid_i && in_ready_o) wr_q <= wr_q + 1'b1;
      if (out_valid_o && out_ready_i) rd_q <= rd_q + 1'b1;
    end
  end
endmodule

// File: rtl/sha384_core.sv
`include "sha384_hash_engine_assert.svh"
module sha384_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             c_valid_i,
  output logic             c_ready_o,
  input  sha384_pkg::cmd_t c_cmd_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [63:0]      m_word_o,
  output logic [2:0]       m_num_o,
  output logic             m_last_o
);
  import sha384_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e      state_q;
  logic [63:0] h_q [8];
  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [3:0]  fill_q;
  logic [6:0]  round_q;
  logic        fin_q;
  logic [2:0]  num_q;
  logic [63:0] s0, s1, wnew, wcur, big0, big1, ch, maj, t1, t2;
  logic        take;

  assign take = c_valid_i && c_ready_o;
  assign c_ready_o = (state_q == ST_LOAD);

  // message schedule runs in a 16-word shift window
  assign s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
  assign s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
  assign wnew = s1 + w_q[9] + s0 + w_q[0];
  assign wcur = w_q[0];
  assign big1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1 = v_q[7] + big1 + ch + ROUND_K[round_q] + wcur;
  assign big0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2 = big0 + maj;

  assign m_tvalid_o = (state_q == ST_OUT);
  assign m_word_o = h_q[num_q];
  assign m_num_o = num_q;
  assign m_last_o = (num_q == 3'd5);

  always_ff @(posedge clk_i) begin
    if (take) begin
      w_q[fill_q] <= c_cmd_i.word;
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
    if (take && fill_q == 4'd15) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == ST_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
      fill_q <= '0;
      round_q <= '0;
      fin_q <= 1'b0;
      num_q <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: if (take) begin
          fill_q <= fill_q + 4'd1;
          if (fill_q == 4'd15) begin
            fin_q <= c_cmd_i.last;
            round_q <= '0;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (round_q == 7'd79) begin
            round_q <= '0;
            state_q <= ST_ADD;
          end else begin
            round_q <= round_q + 7'd1;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          num_q <= '0;
          state_q <= fin_q ? ST_OUT : ST_LOAD;
        end
        ST_OUT: if (m_tready_i) begin
          if (num_q == 3'd5) begin
            num_q <= '0;
            for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
            state_q <= ST_LOAD;
          end else begin
            num_q <= num_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  `SHA_ASSERT(a_round_range, clk_i, rst_ni, round_q <= 7'd79)
  `SHA_ASSERT(a_num_range, clk_i, rst_ni, num_q <= 3'd5)
  `SHA_ASSERT(a_len_ends_block, clk_i, rst_ni, (take && c_cmd_i.op == OP_LEN) |-> fill_q == 4'd15)
  `SHA_ASSERT(a_round_enter, clk_i, rst_ni, $rose(state_q == ST_ROUND) |-> round_q == 7'd0)
endmodule

// File: rtl/sha384_hash_engine.sv
// channel  | dir | tdata                                        | tuser/tlast
// s_axis   | in  | [63:0] message_word, [67:64] valid_bytes     | tlast: end_of_message
// m_axis   | out | [63:0] digest_word, [66:64] word_number      | tlast: last_word
// each full 1024-bit block takes 16 word transfers, then 80 rounds and one add step
// in the single shared round unit; after the final word, padding words follow
// one a cycle unless stalled, then six digest transfers
// asynchronous active-low reset loads the initial hash and clears all counters
// a 4-entry queue parts the padding front end from the round unit
module sha384_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // message_word, valid_bytes, zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // digest_word, word_number, zero fill
  output logic        m_axis_tlast
);
  import sha384_pkg::*;

  logic  f_valid, f_ready, q_valid, q_ready;
  cmd_t  f_cmd, q_cmd;
  logic [63:0] dw;
  logic [2:0]  dn;

  sha384_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_word_i(s_axis_tdata[63:0]), .s_nbytes_i(s_axis_tdata[67:64]),
    .s_last_i(s_axis_tlast),
    .c_valid_o(f_valid), .c_ready_i(f_ready), .c_cmd_o(f_cmd)
  );

  sha384_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_cmd_i(f_cmd),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_cmd_o(q_cmd)
  );

  sha384_core u_core (
    .clk_i, .rst_ni,
    .c_valid_i(q_valid), .c_ready_o(q_ready), .c_cmd_i(q_cmd),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_word_o(dw), .m_num_o(dn), .m_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, dn, dw};
endmodule
